FILE: sv/lsc_pkg.sv
// -----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the 2x2 linear system classifier
// Holds the solution kind codes, the job record passed from the front end to
// the divider back end, and the fixed-point widths.
// -----------------------------------------------------------------------------
package lsc_pkg;

    localparam int QW          = 32;  // Q16.16 word width
    localparam int FRAC        = 16;  // fraction bits
    localparam int PW          = 64;  // product and determinant width
    localparam int QUEUE_DEPTH = 4;   // default depth of the job queue

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_LINE  = 3'd1,
        KIND_POINT = 3'd2,
        KIND_XFIX  = 3'd3,
        KIND_YFIX  = 3'd4,
        KIND_ALL   = 3'd5
    } kind_t;

    // A divisor of zero marks a value slot that is not used; it reads as 0.
    typedef struct packed {
        kind_t                kind;
        logic signed [PW-1:0] num1;
        logic signed [PW-1:0] den1;
        logic signed [PW-1:0] num2;
        logic signed [PW-1:0] den2;
    } job_t;

endpackage

FILE: sv/lsc_front.sv
// -----------------------------------------------------------------------------
// lsc_front: product stage and classifier
// Forms the six exact products, then the three determinants, picks the case
// and the numerator and divisor of each value, and pushes a job.
// -----------------------------------------------------------------------------
module lsc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [lsc_pkg::QW-1:0]  coef_a,
    input  logic signed [lsc_pkg::QW-1:0]  coef_b,
    input  logic signed [lsc_pkg::QW-1:0]  coef_c,
    input  logic signed [lsc_pkg::QW-1:0]  coef_d,
    input  logic signed [lsc_pkg::QW-1:0]  rhs_e,
    input  logic signed [lsc_pkg::QW-1:0]  rhs_f,
    output logic                           push,
    output lsc_pkg::job_t                  job,
    input  logic                           full
);

    logic                          valid_reg;
    logic signed [lsc_pkg::PW-1:0] ad_reg, bc_reg, ed_reg, bf_reg, af_reg, ec_reg;
    logic signed [lsc_pkg::PW-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    logic signed [lsc_pkg::PW-1:0] det, dx, dy;
    logic                          xz, yz;

    assign in_ready = !valid_reg || !full;
    assign push     = valid_reg && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ad_reg <= lsc_pkg::PW'(coef_a * coef_d);
            bc_reg <= lsc_pkg::PW'(coef_b * coef_c);
            ed_reg <= lsc_pkg::PW'(rhs_e * coef_d);
            bf_reg <= lsc_pkg::PW'(coef_b * rhs_f);
            af_reg <= lsc_pkg::PW'(coef_a * rhs_f);
            ec_reg <= lsc_pkg::PW'(rhs_e * coef_c);
            a_reg  <= lsc_pkg::PW'(coef_a);
            b_reg  <= lsc_pkg::PW'(coef_b);
            c_reg  <= lsc_pkg::PW'(coef_c);
            d_reg  <= lsc_pkg::PW'(coef_d);
            e_reg  <= lsc_pkg::PW'(rhs_e);
            f_reg  <= lsc_pkg::PW'(rhs_f);
        end
    end

    // Determinants are formed at 64 bits, like the exact products.
    assign det = ad_reg - bc_reg;
    assign dx  = ed_reg - bf_reg;
    assign dy  = af_reg - ec_reg;
    assign xz  = (a_reg == '0) && (c_reg == '0);
    assign yz  = (b_reg == '0) && (d_reg == '0);

    always_comb
    begin
        job.kind = lsc_pkg::KIND_NONE;
        job.num1 = '0;
        job.den1 = '0;
        job.num2 = '0;
        job.den2 = '0;
        if (det != '0)
        begin
            job.kind = lsc_pkg::KIND_POINT;
            job.num1 = dx;
            job.den1 = det;
            job.num2 = dy;
            job.den2 = det;
        end
        else if (dx != '0 || dy != '0)
        begin
            job.kind = lsc_pkg::KIND_NONE;
        end
        else if (xz && yz)
        begin
            job.kind = (e_reg != '0 || f_reg != '0) ? lsc_pkg::KIND_NONE
                                                    : lsc_pkg::KIND_ALL;
        end
        else if (xz)
        begin
            job.kind = lsc_pkg::KIND_YFIX;
            job.num1 = (b_reg != '0) ? e_reg : f_reg;
            job.den1 = (b_reg != '0) ? b_reg : d_reg;
        end
        else if (yz)
        begin
            job.kind = lsc_pkg::KIND_XFIX;
            job.num1 = (a_reg != '0) ? e_reg : f_reg;
            job.den1 = (a_reg != '0) ? a_reg : c_reg;
        end
        else
        begin
            job.kind = lsc_pkg::KIND_LINE;
            job.num1 = (b_reg != '0) ? -a_reg : -c_reg;
            job.den1 = (b_reg != '0) ? b_reg : d_reg;
            job.num2 = (b_reg != '0) ? e_reg : f_reg;
            job.den2 = (b_reg != '0) ? b_reg : d_reg;
        end
    end

endmodule

FILE: sv/lsc_queue.sv
// -----------------------------------------------------------------------------
// lsc_queue: job queue between classifier and dividers
// A small circular buffer that lets either side stall on its own.
// -----------------------------------------------------------------------------
module lsc_queue #(
    parameter int DEPTH = lsc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lsc_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output lsc_pkg::job_t rdata,
    output logic          empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lsc_pkg::job_t mem [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/lsc_div.sv
// -----------------------------------------------------------------------------
// lsc_div: pipelined Q16.16 divider
// Computes (num * 2^16) / den truncated toward zero and saturated to the
// Q16.16 range, one quotient bit per stage; a zero divisor gives zero.
// -----------------------------------------------------------------------------
module lsc_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [lsc_pkg::PW-1:0] num,
    input  logic signed [lsc_pkg::PW-1:0] den,
    output logic        [lsc_pkg::QW-1:0] value,
    output logic                          sat
);

    localparam int PW = lsc_pkg::PW;
    localparam int QW = lsc_pkg::QW;
    localparam int FR = lsc_pkg::FRAC;

    logic [PW-1:0] nm0_reg, dm0_reg;
    logic          neg0_reg;

    logic [PW-1:0] r_reg    [0:QW];
    logic [PW-1:0] d_reg    [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [FR-1:0] nlo_reg  [0:QW];
    logic          neg_reg  [0:QW];
    logic          zero_reg [0:QW];
    logic          big_reg  [0:QW];

    logic [QW-1:0] qf, limit;

    // Stage 0: magnitudes and sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm0_reg  <= num[PW-1] ? PW'(-num) : PW'(num);
            dm0_reg  <= den[PW-1] ? PW'(-den) : PW'(den);
            neg0_reg <= num[PW-1] ^ den[PW-1];
        end
    end

    // Stage 1: a quotient of 2^32 or more is caught here; otherwise the
    // upper dividend bits already lie below the divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= PW'(nm0_reg >> FR);
            d_reg[0]    <= dm0_reg;
            q_reg[0]    <= '0;
            nlo_reg[0]  <= nm0_reg[FR-1:0];
            neg_reg[0]  <= neg0_reg;
            zero_reg[0] <= (dm0_reg == '0);
            big_reg[0]  <= {{FR{1'b0}}, nm0_reg} >= {dm0_reg, {FR{1'b0}}};
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int BI = QW - 1 - k;
        logic          dbit;
        logic [PW:0]   r2;
        logic [PW:0]   diff;

        if (BI >= FR)
        begin : g_nbit
            assign dbit = nlo_reg[k][BI-FR];
        end
        else
        begin : g_zero
            assign dbit = 1'b0;
        end

        assign r2   = {r_reg[k], dbit};
        assign diff = r2 - {1'b0, d_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]    <= diff[PW] ? r2[PW-1:0] : diff[PW-1:0];
                q_reg[k+1]    <= {q_reg[k][QW-2:0], !diff[PW]};
                d_reg[k+1]    <= d_reg[k];
                nlo_reg[k+1]  <= nlo_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                big_reg[k+1]  <= big_reg[k];
            end
        end
    end

    assign qf    = q_reg[QW];
    assign limit = neg_reg[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign sat   = !zero_reg[QW] && (big_reg[QW] || qf > limit);

    always_comb
    begin
        if (zero_reg[QW])
        begin
            value = '0;
        end
        else if (sat)
        begin
            value = limit;
        end
        else
        begin
            value = neg_reg[QW] ? -qf : qf;
        end
    end

endmodule

FILE: sv/lsc_back.sv
// -----------------------------------------------------------------------------
// lsc_back: divider back end
// Pops jobs, runs both quotients through the divider pipelines and holds
// each result in an output register until it is taken.
// -----------------------------------------------------------------------------
module lsc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsc_pkg::job_t                 job,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    solution_kind,
    output logic signed [lsc_pkg::QW-1:0] first_value,
    output logic signed [lsc_pkg::QW-1:0] second_value,
    output logic                          saturated
);

    // Divider latency: magnitude stage, range stage, one stage per bit.
    localparam int LAT = lsc_pkg::QW + 2;

    logic                    en;
    logic                    v_reg    [0:LAT-1];
    lsc_pkg::kind_t          kind_reg [0:LAT-1];
    logic                    out_valid_reg;
    lsc_pkg::kind_t          kind_out_reg;
    logic [lsc_pkg::QW-1:0]  v1, v2, v1_out_reg, v2_out_reg;
    logic                    s1, s2, sat_out_reg;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !empty;

    lsc_div u_div1 (
        .clk   (clk),
        .en    (en),
        .num   (job.num1),
        .den   (job.den1),
        .value (v1),
        .sat   (s1)
    );

    lsc_div u_div2 (
        .clk   (clk),
        .en    (en),
        .num   (job.num2),
        .den   (job.den2),
        .value (v2),
        .sat   (s2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= !empty;
            for (int i = 1; i < LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg[0] <= job.kind;
            for (int i = 1; i < LAT; i++)
            begin
                kind_reg[i] <= kind_reg[i-1];
            end
            kind_out_reg <= kind_reg[LAT-1];
            v1_out_reg   <= v1;
            v2_out_reg   <= v2;
            sat_out_reg  <= s1 || s2;
        end
    end

    assign out_valid     = out_valid_reg;
    assign solution_kind = kind_out_reg;
    assign first_value   = v1_out_reg;
    assign second_value  = v2_out_reg;
    assign saturated     = sat_out_reg;

endmodule

FILE: sv/linear_system_2x2_classifier_core.sv
// -----------------------------------------------------------------------------
// linear_system_2x2_classifier_core: 2x2 linear system solver, Q16.16
// Classifies a*x + b*y = e, c*x + d*y = f and returns the solution kind with
// up to two saturated Q16.16 values.
// -----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one system per transfer as
// six signed Q16.16 coefficients. The output channel (out_valid/out_ready)
// carries one result per transfer: the kind code, two values and a flag
// that is set when a quotient was clipped to the Q16.16 range.
// The front end registers the six exact 64-bit products, forms the three
// determinants and classifies the system in the next cycle, then writes a
// job into a short queue. The back end pops one job per cycle, unless the
// output is stalled, into two bit-serial-per-stage divider pipelines of 34
// stages and an output register. Throughput is one system per cycle while
// the output is not stalled; the 32 restoring steps of each divider set the
// depth, not the rate. When a result is held with out_ready low, the back
// end pipeline holds as a whole; the queue then fills and the front end
// keeps accepting until the queue is full, after which in_ready drops.
// Reset clears all valid flags and the queue; no result is presented until
// a new system is accepted.
// -----------------------------------------------------------------------------
module linear_system_2x2_classifier_core #(
    parameter int QUEUE_DEPTH = lsc_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [lsc_pkg::QW-1:0] coef_a,
    input  logic signed [lsc_pkg::QW-1:0] coef_b,
    input  logic signed [lsc_pkg::QW-1:0] coef_c,
    input  logic signed [lsc_pkg::QW-1:0] coef_d,
    input  logic signed [lsc_pkg::QW-1:0] rhs_e,
    input  logic signed [lsc_pkg::QW-1:0] rhs_f,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    solution_kind,
    output logic signed [lsc_pkg::QW-1:0] first_value,
    output logic signed [lsc_pkg::QW-1:0] second_value,
    output logic                          saturated
);

    lsc_pkg::job_t push_job, pop_job;
    logic          push, pop, full, empty;

    // Front end: products, determinants and classification.
    lsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .coef_c   (coef_c),
        .coef_d   (coef_d),
        .rhs_e    (rhs_e),
        .rhs_f    (rhs_f),
        .push     (push),
        .job      (push_job),
        .full     (full)
    );

    // The queue decouples the classifier from divider stalls.
    lsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_job),
        .full  (full),
        .pop   (pop),
        .rdata (pop_job),
        .empty (empty)
    );

    // Back end: both quotients and the output register.
    lsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (pop_job),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .solution_kind (solution_kind),
        .first_value   (first_value),
        .second_value  (second_value),
        .saturated     (saturated)
    );

endmodule

FILE: sv/lsc_checker.sv
// -----------------------------------------------------------------------------
// lsc_port_checker: port-level checks of the classifier
// Watches the result channel for hold behavior and consistent fields.
// -----------------------------------------------------------------------------
module lsc_port_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [2:0]                    solution_kind,
    input  logic signed [lsc_pkg::QW-1:0] first_value,
    input  logic signed [lsc_pkg::QW-1:0] second_value,
    input  logic                          saturated
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Kinds without values carry zeros and never a clip.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (solution_kind == lsc_pkg::KIND_NONE ||
                      solution_kind == lsc_pkg::KIND_ALL)
        |-> first_value == '0 && second_value == '0 && !saturated)
        else $error("value on a kind without values");

    // Single-value kinds leave the second value at zero.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (solution_kind == lsc_pkg::KIND_XFIX ||
                      solution_kind == lsc_pkg::KIND_YFIX)
        |-> second_value == '0)
        else $error("second value on a single-value kind");

    // A clipped XFIX result has its first value at one of the two range limits.
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated && solution_kind == lsc_pkg::KIND_XFIX
        |-> first_value == 32'sh7FFF_FFFF || first_value == 32'sh8000_0000)
        else $error("clipped value not at a limit");

endmodule

bind linear_system_2x2_classifier_core lsc_port_checker u_lsc_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .solution_kind (solution_kind),
    .first_value   (first_value),
    .second_value  (second_value),
    .saturated     (saturated)
);

FILE: test/lsc_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lsc_checker: result predictor and scoreboard for the 2x2 system classifier
// Watches both channels of the block. Every accepted system is solved here
// with wide integer arithmetic and the expected result is queued. Every
// accepted result is compared field by field with the oldest expectation.
// -----------------------------------------------------------------------------
module lsc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [lsc_pkg::QW-1:0] coef_a,
    input  logic signed [lsc_pkg::QW-1:0] coef_b,
    input  logic signed [lsc_pkg::QW-1:0] coef_c,
    input  logic signed [lsc_pkg::QW-1:0] coef_d,
    input  logic signed [lsc_pkg::QW-1:0] rhs_e,
    input  logic signed [lsc_pkg::QW-1:0] rhs_f,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [2:0]                    solution_kind,
    input  logic signed [lsc_pkg::QW-1:0] first_value,
    input  logic signed [lsc_pkg::QW-1:0] second_value,
    input  logic                          saturated,
    output int                            error_count,
    output int                            pending_count
);

    typedef struct {
        lsc_pkg::kind_t          kind;
        logic [lsc_pkg::QW-1:0]  v1;
        logic [lsc_pkg::QW-1:0]  v2;
        logic                    sat;
    } solution_t;

    solution_t solution_queue[$];

    // Truncating Q16.16 quotient of num / den, clipped to the signed range.
    function automatic logic [lsc_pkg::QW-1:0] q16_divide(input logic signed [127:0] num,
                                                          input logic signed [127:0] den,
                                                          inout logic sat);
        logic         neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] limit;
        if (den == 0)
            return '0;
        neg   = (num < 0) != (den < 0);
        n     = (num < 0) ? -num : num;
        d     = (den < 0) ? -den : den;
        q     = (n << lsc_pkg::FRAC) / d;
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > limit)
        begin
            q   = limit;
            sat = 1'b1;
        end
        if (neg)
            q = -q;
        return q[lsc_pkg::QW-1:0];
    endfunction

    function automatic solution_t solve_system(input logic signed [127:0] a,
                                               input logic signed [127:0] b,
                                               input logic signed [127:0] c,
                                               input logic signed [127:0] d,
                                               input logic signed [127:0] e,
                                               input logic signed [127:0] f);
        solution_t               s;
        logic signed [127:0]     det;
        logic signed [127:0]     dx;
        logic signed [127:0]     dy;
        logic                    xz;
        logic                    yz;
        det   = a * d - b * c;
        dx    = e * d - b * f;
        dy    = a * f - e * c;
        xz    = (a == 0) && (c == 0);
        yz    = (b == 0) && (d == 0);
        s.kind = lsc_pkg::KIND_NONE;
        s.v1   = '0;
        s.v2   = '0;
        s.sat  = 1'b0;
        if (det != 0)
        begin
            s.kind = lsc_pkg::KIND_POINT;
            s.v1   = q16_divide(dx, det, s.sat);
            s.v2   = q16_divide(dy, det, s.sat);
        end
        else if (dx != 0 || dy != 0)
            s.kind = lsc_pkg::KIND_NONE;
        else if (xz && yz)
            s.kind = (e != 0 || f != 0) ? lsc_pkg::KIND_NONE : lsc_pkg::KIND_ALL;
        else if (xz)
        begin
            s.kind = lsc_pkg::KIND_YFIX;
            s.v1   = (b != 0) ? q16_divide(e, b, s.sat) : q16_divide(f, d, s.sat);
        end
        else if (yz)
        begin
            s.kind = lsc_pkg::KIND_XFIX;
            s.v1   = (a != 0) ? q16_divide(e, a, s.sat) : q16_divide(f, c, s.sat);
        end
        else
        begin
            s.kind = lsc_pkg::KIND_LINE;
            if (b != 0)
            begin
                s.v1 = q16_divide(-a, b, s.sat);
                s.v2 = q16_divide(e, b, s.sat);
            end
            else
            begin
                s.v1 = q16_divide(-c, d, s.sat);
                s.v2 = q16_divide(f, d, s.sat);
            end
        end
        return s;
    endfunction

    assign pending_count = solution_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        solution_t exp_sol;
        if (!rst_n)
        begin
            error_count = 0;
            solution_queue.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                solution_queue.push_back(solve_system(128'(coef_a), 128'(coef_b),
                                                      128'(coef_c), 128'(coef_d),
                                                      128'(rhs_e), 128'(rhs_f)));
            if (out_valid && out_ready)
            begin
                if (solution_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result kind %0d", $time, solution_kind);
                end
                else
                begin
                    exp_sol = solution_queue.pop_front();
                    if (solution_kind !== exp_sol.kind)
                    begin
                        error_count++;
                        $display("%0t: kind expected %0d actual %0d", $time,
                                 exp_sol.kind, solution_kind);
                    end
                    if (first_value !== exp_sol.v1)
                    begin
                        error_count++;
                        $display("%0t: first_value expected %h actual %h", $time,
                                 exp_sol.v1, first_value);
                    end
                    if (second_value !== exp_sol.v2)
                    begin
                        error_count++;
                        $display("%0t: second_value expected %h actual %h", $time,
                                 exp_sol.v2, second_value);
                    end
                    if (saturated !== exp_sol.sat)
                    begin
                        error_count++;
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_sol.sat, saturated);
                    end
                end
            end
        end
    end

endmodule

FILE: test/tb_linear_system_2x2_classifier_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_linear_system_2x2_classifier_core: stimulus and verdict for the classifier
// Drives directed corner systems and then a few hundred random systems shaped
// to reach every solution kind, with random gaps on both channels, a long
// receiver stall and a drain pause. The checker does all comparison.
// -----------------------------------------------------------------------------
module tb_linear_system_2x2_classifier_core;

    localparam int MAX_Q = 32'h7FFF_FFFF;
    localparam int MIN_Q = 32'h8000_0000;
    localparam int ONE_Q = 32'h0001_0000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [lsc_pkg::QW-1:0] coef_a;
    logic signed [lsc_pkg::QW-1:0] coef_b;
    logic signed [lsc_pkg::QW-1:0] coef_c;
    logic signed [lsc_pkg::QW-1:0] coef_d;
    logic signed [lsc_pkg::QW-1:0] rhs_e;
    logic signed [lsc_pkg::QW-1:0] rhs_f;
    logic                          out_valid;
    logic                          out_ready;
    logic [2:0]                    solution_kind;
    logic signed [lsc_pkg::QW-1:0] first_value;
    logic signed [lsc_pkg::QW-1:0] second_value;
    logic                          saturated;
    int                            error_count;
    int                            pending_count;
    bit                            stimulus_done;

    linear_system_2x2_classifier_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coef_a       (coef_a),
        .coef_b       (coef_b),
        .coef_c       (coef_c),
        .coef_d       (coef_d),
        .rhs_e        (rhs_e),
        .rhs_f        (rhs_f),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .solution_kind(solution_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .saturated    (saturated)
    );

    lsc_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coef_a       (coef_a),
        .coef_b       (coef_b),
        .coef_c       (coef_c),
        .coef_d       (coef_d),
        .rhs_e        (rhs_e),
        .rhs_f        (rhs_f),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .solution_kind(solution_kind),
        .first_value  (first_value),
        .second_value (second_value),
        .saturated    (saturated),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Gap length: mostly zero or short, occasionally long.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One coefficient drawn from full-range, small, zero or extreme values.
    function automatic int pick_coef();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2:    return int'($urandom_range(0, 262144)) - 131072;
            3:    return 0;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return MAX_Q;
                    1: return MIN_Q;
                    2: return -1;
                    3: return ONE_Q;
                    default: return -ONE_Q;
                endcase
            end
        endcase
    endfunction

    // Receiver side. It runs its own cycle count and, once early in the run,
    // holds off for a long stretch so that the job queue fills and the block
    // has to drop in_ready while the sender keeps offering systems.
    initial
    begin
        int cycle;
        int gap;
        bit stalled;
        out_ready = 1'b0;
        cycle     = 0;
        stalled   = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!stalled && cycle >= 150)
            begin
                stalled = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                cycle += 300;
            end
            gap = gap_length();
            if (gap == 0)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
                cycle++;
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                cycle += gap;
            end
        end
    end

    // Offer one system and hold it until the transfer. in_ready is sampled
    // at the falling edge, where it is stable ahead of the next rising edge.
    task automatic send_system(input int a, input int b, input int c,
                               input int d, input int e, input int f);
        bit took;
        int gap;
        in_valid <= 1'b1;
        coef_a   <= a;
        coef_b   <= b;
        coef_c   <= c;
        coef_d   <= d;
        rhs_e    <= e;
        rhs_f    <= f;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_system();
        int a, b, c, d, e, f, m;
        m = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                a = pick_coef(); b = pick_coef(); c = pick_coef();
                d = pick_coef(); e = pick_coef(); f = pick_coef();
            end
            4, 5:
            begin
                // Dependent rows: a line (x fixed when b is 0) or no solution.
                a = int'($urandom_range(0, 131072)) - 65536;
                b = int'($urandom_range(0, 131072)) - 65536;
                e = int'($urandom_range(0, 131072)) - 65536;
                if ($urandom_range(0, 3) == 0)
                    b = 0;
                c = a * m;
                d = b * m;
                f = e * m + (($urandom_range(0, 3) == 0) ? 1 : 0);
            end
            6:
            begin
                // No x terms: y is fixed when the rows agree.
                a = 0; c = 0;
                b = ($urandom_range(0, 3) == 0) ? 0 : pick_coef() >>> 8;
                e = (b == 0) ? 0 : pick_coef() >>> 8;
                d = (b == 0) ? pick_coef() : b * m;
                f = (b == 0) ? pick_coef() : e * m;
            end
            7:
            begin
                // No y terms: x is fixed when the rows agree.
                b = 0; d = 0;
                a = ($urandom_range(0, 3) == 0) ? 0 : pick_coef() >>> 8;
                e = (a == 0) ? 0 : pick_coef() >>> 8;
                c = (a == 0) ? pick_coef() : a * m;
                f = (a == 0) ? pick_coef() : e * m;
            end
            8:
            begin
                a = 0; b = 0; c = 0; d = 0;
                e = ($urandom_range(0, 1) == 0) ? 0 : pick_coef();
                f = ($urandom_range(0, 1) == 0) ? 0 : pick_coef();
            end
            default:
            begin
                // Tiny determinant with large numerators forces clipping unless b is 0.
                a = pick_coef(); b = pick_coef();
                c = a + 1; d = b;
                e = MAX_Q; f = MIN_Q;
            end
        endcase
        send_system(a, b, c, d, e, f);
    endtask

    // Stimulus.
    initial
    begin
        in_valid      = 1'b0;
        coef_a        = '0;
        coef_b        = '0;
        coef_c        = '0;
        coef_d        = '0;
        rhs_e         = '0;
        rhs_f         = '0;
        stimulus_done = 1'b0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed systems: one of every kind plus extremes and clipping.
        send_system(ONE_Q, 0, 0, ONE_Q, 3 * ONE_Q, -2 * ONE_Q);
        send_system(2 * ONE_Q, ONE_Q, ONE_Q, 3 * ONE_Q, 5 * ONE_Q, 10 * ONE_Q);
        send_system(MAX_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MIN_Q);
        send_system(MIN_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q);
        send_system(1, 0, 0, 1, MAX_Q, MIN_Q);
        send_system(1, 0, 0, -1, MIN_Q, MIN_Q);
        send_system(-1, -1, -1, -1, -1, -1);
        send_system(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 2 * ONE_Q);
        send_system(ONE_Q, 2 * ONE_Q, 2 * ONE_Q, 4 * ONE_Q, ONE_Q, 2 * ONE_Q);
        send_system(ONE_Q, 0, 2 * ONE_Q, 0, 3 * ONE_Q, 6 * ONE_Q);
        send_system(1, 1, 2, 2, MAX_Q, -2);
        send_system(0, 0, ONE_Q, MIN_Q, 0, ONE_Q);
        send_system(0, ONE_Q, 0, 2 * ONE_Q, -ONE_Q, -2 * ONE_Q);
        send_system(0, 0, 0, 1, 0, MAX_Q);
        send_system(0, 1, 0, 0, MIN_Q, 0);
        send_system(ONE_Q, 0, 3 * ONE_Q, 0, 2 * ONE_Q, 6 * ONE_Q);
        send_system(0, 0, 1, 0, 0, MIN_Q);
        send_system(1, 0, 0, 0, MAX_Q, 0);
        send_system(0, 0, 0, 0, 0, 0);
        send_system(0, 0, 0, 0, 0, 1);
        send_system(0, 0, 0, 0, MIN_Q, 0);
        send_system(0, 1, 0, 1, ONE_Q, 2 * ONE_Q);
        send_system(-1, 1, -1, 1, 0, 0);

        // Pause until every directed result has come back.
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);

        repeat (500)
            send_random_system();
        in_valid      <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Verdict once the block has drained.
    initial
    begin
        @(posedge stimulus_done);
        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
